### rtl/mpgas_pkg.sv
// ----------------------------------------------------------------------------
// mpgas_pkg
// Shared types, constants and lookup tables for the MPEG audio frame sync
// and header parse unit.
// ----------------------------------------------------------------------------
package mpgas_pkg;

  // Defaults for the top-level parameters
  localparam int COUNT_BITS_DEF  = 24;
  localparam int QUEUE_DEPTH_DEF = 2;

  // Configuration register indexes
  localparam logic [1:0] CFG_TEMPLATE = 2'd0;
  localparam logic [1:0] CFG_LIMIT    = 2'd1;
  localparam logic [1:0] CFG_LAYER1   = 2'd2;

  localparam logic [31:0] TEMPLATE_MASK = 32'hffff0c00;
  localparam logic [31:0] SYNC_BITS     = 32'hffe00000;
  localparam logic [23:0] SKIP_MAX      = 24'hffffff;

  // Frame size numerator: K * bitrate, K up to 144000, bitrate up to 448
  localparam int PROD_W = 26;
  localparam int FREQ_W = 16;
  localparam logic [17:0] K_LAYER1 = 18'd12000;
  localparam logic [17:0] K_FULL   = 18'd144000;
  localparam logic [17:0] K_HALF   = 18'd72000;

  // Event passed from the front end to the decode back end
  typedef struct packed {
    logic        status;
    logic [23:0] skipped;
    logic [31:0] header;
  } evt_t;

  // One result item
  typedef struct packed {
    logic        status;
    logic [23:0] skipped_bytes;
    logic [31:0] header_word;
    logic [1:0]  mpeg_version;
    logic [1:0]  layer_index;
    logic [8:0]  bitrate_kbps;
    logic [15:0] sample_rate_hz;
    logic [11:0] frame_bytes;
    logic [10:0] samples_per_frame;
    logic [12:0] frame_time_num;
    logic [7:0]  frame_time_den;
  } res_t;

  // Bitrate rows: MPEG-1 layers I..III, then MPEG-2/2.5 layer I, layers II/III
  localparam logic [8:0] RATE_TAB [0:4][0:15] = '{
    '{0, 32, 64, 96, 128, 160, 192, 224, 256, 288, 320, 352, 384, 416, 448, 0},
    '{0, 32, 48, 56, 64, 80, 96, 112, 128, 160, 192, 224, 256, 320, 384, 0},
    '{0, 32, 40, 48, 56, 64, 80, 96, 112, 128, 160, 192, 224, 256, 320, 0},
    '{0, 32, 48, 56, 64, 80, 96, 112, 128, 144, 160, 176, 192, 224, 256, 0},
    '{0, 8, 16, 24, 32, 40, 48, 56, 64, 80, 96, 112, 128, 144, 160, 0}
  };

  // Sample rate by version and rate index
  localparam logic [15:0] FREQ_TAB [0:2][0:2] = '{
    '{44100, 48000, 32000},
    '{22050, 24000, 16000},
    '{11025, 12000, 8000}
  };

  // Frame time numerator by layer, version and rate index
  localparam logic [12:0] NUM_TAB [0:2][0:2][0:2] = '{
    '{'{1280, 8, 12},  '{2560, 16, 24}, '{5120, 32, 48}},
    '{'{1280, 24, 36}, '{2560, 48, 72}, '{5120, 96, 144}},
    '{'{1280, 24, 36}, '{1280, 24, 36}, '{2560, 48, 72}}
  };

endpackage

### rtl/mpeg_audio_frame_sync_parse_unit.sv
// ----------------------------------------------------------------------------
// mpeg_audio_frame_sync_parse_unit
// Path: a timeout result moves from the event queue into the back end's
//   working register, then into the output register once that is free; a
//   decoded header first passes table load, multiply and the 26-step divider.
// Throughput: one byte per cycle while the event queue has room; the back end
//   takes the next event only once the last has gone to the output register.
// Reset: synchronous, active low; clears search state, queue and registers
//   (limit 0, template 0, Layer I accepted). No clearing pass.
// ----------------------------------------------------------------------------
module mpeg_audio_frame_sync_parse_unit
  import mpgas_pkg::*;
#(
  parameter int COUNT_BITS  = COUNT_BITS_DEF,
  parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_push,
  output logic        in_full,
  input  logic [7:0]  in_stream_byte,
  input  logic        in_restart,
  output logic        out_empty,
  input  logic        out_pop,
  output logic        out_status,
  output logic [23:0] out_skipped_bytes,
  output logic [31:0] out_header_word,
  output logic [1:0]  out_mpeg_version,
  output logic [1:0]  out_layer_index,
  output logic [8:0]  out_bitrate_kbps,
  output logic [15:0] out_sample_rate_hz,
  output logic [11:0] out_frame_bytes,
  output logic [10:0] out_samples_per_frame,
  output logic [12:0] out_frame_time_num,
  output logic [7:0]  out_frame_time_den,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [31:0] cfg_data
);

  logic [31:0] template_r;
  logic [23:0] limit_r;
  logic        layer1_r;

  logic accept;
  logic evt_push;
  evt_t evt;
  evt_t q_head;
  logic q_full;
  logic q_empty;
  logic q_pop;
  res_t res;
  logic res_valid;

  assign in_full = q_full;
  assign accept  = in_push && !q_full;

  // Hold configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      template_r <= '0;
      limit_r    <= '0;
      layer1_r   <= 1'b1;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_TEMPLATE: template_r <= cfg_data;
        CFG_LIMIT:    limit_r    <= cfg_data[23:0];
        CFG_LAYER1:   layer1_r   <= cfg_data[0];
        default:      ;
      endcase
    end
  end

  mpgas_front #(
    .COUNT_BITS (COUNT_BITS)
  ) u_front (
    .clk             (clk),
    .rst_n           (rst_n),
    .accept          (accept),
    .stream_byte     (in_stream_byte),
    .restart         (in_restart),
    .template_header (template_r),
    .search_limit    (limit_r),
    .accept_layer1   (layer1_r),
    .evt_push        (evt_push),
    .evt             (evt)
  );

  mpgas_fifo #(
    .DEPTH (QUEUE_DEPTH)
  ) u_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (evt_push),
    .push_data (evt),
    .pop       (q_pop),
    .head      (q_head),
    .full      (q_full),
    .empty     (q_empty)
  );

  mpgas_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .head      (q_head),
    .q_empty   (q_empty),
    .q_pop     (q_pop),
    .res       (res),
    .res_valid (res_valid),
    .res_pop   (out_pop)
  );

  // Drive result ports from the output register
  assign out_empty             = !res_valid;
  assign out_status            = res.status;
  assign out_skipped_bytes     = res.skipped_bytes;
  assign out_header_word       = res.header_word;
  assign out_mpeg_version      = res.mpeg_version;
  assign out_layer_index       = res.layer_index;
  assign out_bitrate_kbps      = res.bitrate_kbps;
  assign out_sample_rate_hz    = res.sample_rate_hz;
  assign out_frame_bytes       = res.frame_bytes;
  assign out_samples_per_frame = res.samples_per_frame;
  assign out_frame_time_num    = res.frame_time_num;
  assign out_frame_time_den    = res.frame_time_den;

endmodule

### rtl/mpgas_fifo.sv
// ----------------------------------------------------------------------------
// mpgas_fifo
// Short event queue between the sync front end and the decode back end.
// ----------------------------------------------------------------------------
module mpgas_fifo
  import mpgas_pkg::*;
#(
  parameter int DEPTH = QUEUE_DEPTH_DEF
) (
  input  logic clk,
  input  logic rst_n,
  input  logic push,
  input  evt_t push_data,
  input  logic pop,
  output evt_t head,
  output logic full,
  output logic empty
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  evt_t             mem_r [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r;
  logic [PTR_W-1:0] rd_ptr_r;
  logic [CNT_W-1:0] count_r;

  logic do_push;
  logic do_pop;

  assign full    = (count_r == CNT_W'(DEPTH));
  assign empty   = (count_r == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign head    = mem_r[rd_ptr_r];

  // Store pushed events
  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= push_data;
    end
  end

  // Advance pointers and occupancy
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_r <= (wr_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_r + PTR_W'(1);
      end
      if (do_pop) begin
        rd_ptr_r <= (rd_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_r + PTR_W'(1);
      end
      if (do_push && !do_pop) begin
        count_r <= count_r + CNT_W'(1);
      end else if (do_pop && !do_push) begin
        count_r <= count_r - CNT_W'(1);
      end
    end
  end

endmodule

### rtl/mpgas_front.sv
// ----------------------------------------------------------------------------
// mpgas_front
// Byte window, search counter, limit check and header validity check.
// Emits one event per finished search.
// ----------------------------------------------------------------------------
module mpgas_front
  import mpgas_pkg::*;
#(
  parameter int COUNT_BITS = COUNT_BITS_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        accept,
  input  logic [7:0]  stream_byte,
  input  logic        restart,
  input  logic [31:0] template_header,
  input  logic [23:0] search_limit,
  input  logic        accept_layer1,
  output logic        evt_push,
  output evt_t        evt
);

  localparam int WIDE = (COUNT_BITS > 24) ? COUNT_BITS : 24;
  localparam logic [COUNT_BITS-1:0] CNT_MAX = {COUNT_BITS{1'b1}};

  logic [31:0]           window_r;
  logic [COUNT_BITS-1:0] count_r;
  logic [31:0]           window_nxt;
  logic [COUNT_BITS-1:0] count_nxt;

  logic [31:0]           win_base;
  logic [COUNT_BITS-1:0] cnt_base;
  logic [WIDE-1:0]       cnt_w;
  logic [WIDE-1:0]       skip_w;
  logic                  armed;
  logic                  timeout;
  logic                  found;
  logic                  hdr_ok;
  logic [31:0]           tpl;

  // Header validity against sync, field ranges and the template
  always_comb begin
    tpl    = template_header & TEMPLATE_MASK;
    hdr_ok = 1'b1;
    if ((window_nxt & SYNC_BITS) != SYNC_BITS) hdr_ok = 1'b0;
    if (window_nxt[20:19] == 2'b01) hdr_ok = 1'b0;
    if (window_nxt[18:17] == 2'b00) hdr_ok = 1'b0;
    if (window_nxt[18:17] == 2'b11 && !accept_layer1) hdr_ok = 1'b0;
    if (window_nxt[15:12] == 4'hf || window_nxt[15:12] == 4'h0) hdr_ok = 1'b0;
    if (window_nxt[11:10] == 2'b11) hdr_ok = 1'b0;
    if (tpl != '0 && (window_nxt & TEMPLATE_MASK) != tpl) hdr_ok = 1'b0;
  end

  // Shift in the byte, count it and classify the search
  always_comb begin
    win_base   = restart ? '0 : window_r;
    cnt_base   = restart ? '0 : count_r;
    window_nxt = {win_base[23:0], stream_byte};
    count_nxt  = (cnt_base == CNT_MAX) ? cnt_base : cnt_base + COUNT_BITS'(1);
    cnt_w      = WIDE'(count_nxt);
    armed      = (count_nxt >= COUNT_BITS'(4));
    timeout    = armed && (search_limit != '0) && (cnt_w > WIDE'(search_limit));
    found      = armed && !timeout && hdr_ok;
    skip_w     = cnt_w - WIDE'(4);

    evt_push    = accept && (timeout || found);
    evt.status  = timeout;
    evt.skipped = (skip_w > WIDE'(SKIP_MAX)) ? SKIP_MAX : skip_w[23:0];
    evt.header  = window_nxt;
  end

  // Hold search state; drop it once the search ends
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      window_r <= '0;
      count_r  <= '0;
    end else if (accept) begin
      if (timeout || found) begin
        window_r <= '0;
        count_r  <= '0;
      end else begin
        window_r <= window_nxt;
        count_r  <= count_nxt;
      end
    end
  end

endmodule

### rtl/mpgas_div.sv
// ----------------------------------------------------------------------------
// mpgas_div
// Restoring divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module mpgas_div
  import mpgas_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  input  logic [PROD_W-1:0] num,
  input  logic [FREQ_W-1:0] den,
  output logic              done,
  output logic [PROD_W-1:0] quot
);

  localparam int ITER_W = $clog2(PROD_W);

  logic              busy_r;
  logic              done_r;
  logic [ITER_W-1:0] iter_r;
  logic [PROD_W-1:0] num_r;
  logic [FREQ_W-1:0] den_r;
  logic [FREQ_W-1:0] rem_r;

  logic [FREQ_W:0]   rem_s;
  logic              ge;
  logic [FREQ_W-1:0] rem_nxt;

  assign done = done_r;
  assign quot = num_r;

  // One trial subtraction
  always_comb begin
    rem_s   = {rem_r, num_r[PROD_W-1]};
    ge      = (rem_s >= {1'b0, den_r});
    rem_nxt = ge ? FREQ_W'(rem_s - {1'b0, den_r}) : rem_s[FREQ_W-1:0];
  end

  // Shift quotient bits in as the dividend moves out
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      iter_r <= '0;
    end else begin
      done_r <= !start && busy_r && (iter_r == ITER_W'(PROD_W - 1));
      if (start) begin
        busy_r <= 1'b1;
        iter_r <= '0;
        num_r  <= num;
        den_r  <= den;
        rem_r  <= '0;
      end else if (busy_r) begin
        rem_r <= rem_nxt;
        num_r <= {num_r[PROD_W-2:0], ge};
        if (iter_r == ITER_W'(PROD_W - 1)) begin
          busy_r <= 1'b0;
        end else begin
          iter_r <= iter_r + ITER_W'(1);
        end
      end
    end
  end

endmodule

### rtl/mpgas_back.sv
// ----------------------------------------------------------------------------
// mpgas_back
// Header decode back end: table lookups, frame size multiply and divide,
// and the result output register.
// ----------------------------------------------------------------------------
module mpgas_back
  import mpgas_pkg::*;
(
  input  logic clk,
  input  logic rst_n,
  input  evt_t head,
  input  logic q_empty,
  output logic q_pop,
  output res_t res,
  output logic res_valid,
  input  logic res_pop
);

  typedef enum logic [1:0] {
    S_IDLE,
    S_MUL,
    S_DIV,
    S_DONE
  } state_t;

  state_t            state_r;
  res_t              work_r;
  res_t              res_r;
  logic              res_valid_r;
  logic [17:0]       k_r;
  logic              pad_r;
  logic [PROD_W-1:0] prod_r;
  logic              div_start_r;

  logic              div_done;
  logic [PROD_W-1:0] div_quot;
  logic [PROD_W-1:0] size_w;

  logic [1:0]  ver;
  logic [1:0]  layer;
  logic [1:0]  fidx;
  logic [2:0]  row;
  logic [10:0] samples;
  logic [7:0]  den;
  logic [17:0] k_sel;
  res_t        work_load;
  logic        out_free;

  assign q_pop     = (state_r == S_IDLE) && !q_empty;
  assign res       = res_r;
  assign res_valid = res_valid_r;
  assign out_free  = !res_valid_r || res_pop;

  // Decode the fields of the queue head
  always_comb begin
    case (head.header[20:19])
      2'b11:   ver = 2'd0;
      2'b10:   ver = 2'd1;
      default: ver = 2'd2;
    endcase
    case (head.header[18:17])
      2'b11:   layer = 2'd0;
      2'b10:   layer = 2'd1;
      default: layer = 2'd2;
    endcase
    fidx = (head.header[11:10] == 2'b11) ? 2'd2 : head.header[11:10];
    if (ver == 2'd0) begin
      row = {1'b0, layer};
    end else begin
      row = (layer == 2'd0) ? 3'd3 : 3'd4;
    end
    if (layer == 2'd0) begin
      samples = 11'd384;
      k_sel   = K_LAYER1;
    end else if (ver != 2'd0 && layer == 2'd2) begin
      samples = 11'd576;
      k_sel   = K_HALF;
    end else begin
      samples = 11'd1152;
      k_sel   = K_FULL;
    end
    if (fidx != 2'd0) begin
      den = 8'd1;
    end else begin
      den = (layer == 2'd0) ? 8'd147 : 8'd49;
    end

    // Build the working transaction; a timeout keeps only status and skip count
    work_load               = '0;
    work_load.status        = head.status;
    work_load.skipped_bytes = head.skipped;
    if (!head.status) begin
      work_load.header_word       = head.header;
      work_load.mpeg_version      = ver;
      work_load.layer_index       = layer;
      work_load.bitrate_kbps      = RATE_TAB[row][head.header[15:12]];
      work_load.sample_rate_hz    = FREQ_TAB[ver][fidx];
      work_load.samples_per_frame = samples;
      work_load.frame_time_num    = NUM_TAB[layer][ver][fidx];
      work_load.frame_time_den    = den;
    end
  end

  // Frame bytes from the quotient and padding
  always_comb begin
    if (work_r.layer_index == 2'd0) begin
      size_w = PROD_W'((div_quot + PROD_W'(pad_r)) << 2);
    end else begin
      size_w = div_quot + PROD_W'(pad_r);
    end
  end

  mpgas_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (div_start_r),
    .num   (prod_r),
    .den   (work_r.sample_rate_hz),
    .done  (div_done),
    .quot  (div_quot)
  );

  // Sequence one event through decode and into the output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      res_valid_r <= 1'b0;
      div_start_r <= 1'b0;
    end else begin
      div_start_r <= (state_r == S_MUL);
      res_valid_r <= ((state_r == S_DONE) && out_free) || (res_valid_r && !res_pop);
      case (state_r)
        S_IDLE: begin
          if (!q_empty) begin
            work_r <= work_load;
            if (head.status) begin
              state_r <= S_DONE;
            end else begin
              k_r     <= k_sel;
              pad_r   <= head.header[9];
              state_r <= S_MUL;
            end
          end
        end
        S_MUL: begin
          prod_r  <= PROD_W'(k_r) * PROD_W'(work_r.bitrate_kbps);
          state_r <= S_DIV;
        end
        S_DIV: begin
          if (div_done) begin
            work_r.frame_bytes <= size_w[11:0];
            state_r            <= S_DONE;
          end
        end
        S_DONE: begin
          if (out_free) begin
            res_r   <= work_r;
            state_r <= S_IDLE;
          end
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

endmodule
